// ===== hdl/ctdi_pkg.sv =====
// ----------------------------------------------------------------------------
// ctdi_pkg
// shared types, widths and the per-branch delay table of the time deinterleaver
// ----------------------------------------------------------------------------
package ctdi_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int UNITS_W   = 10;
	localparam int UNIT_LEN_W = 6;                    // 64 samples per capacity unit
	localparam int POS_W     = UNITS_W + UNIT_LEN_W;  // position within a frame
	localparam int SLOT_W    = 4;                     // 16 frame slots in the ring
	localparam int ADDR_W    = SLOT_W + POS_W;        // store address {slot, position}
	localparam int BRANCH_W  = 4;                     // branch index = position mod 16

	localparam logic [UNITS_W-1:0] MAX_UNITS = UNITS_W'(864);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [UNITS_W-1:0]         units_t;
	typedef logic [POS_W-1:0]           pos_t;
	typedef logic [SLOT_W-1:0]          slot_t;
	typedef logic [ADDR_W-1:0]          addr_t;

	// delay in whole frames for each branch
	localparam slot_t DELAY_TAB [16] = '{
		4'd15, 4'd7, 4'd11, 4'd3, 4'd13, 4'd5, 4'd9, 4'd1,
		4'd14, 4'd6, 4'd10, 4'd2, 4'd12, 4'd4, 4'd8, 4'd0
	};

	// one access pair to the sample store
	typedef struct packed {
		logic    we;
		addr_t   waddr;
		sample_t wdata;
		logic    re;
		addr_t   raddr;
	} ctdi_req_t;

endpackage

// ===== hdl/ctdi_if.sv =====
// ----------------------------------------------------------------------------
// ctdi_if
// valid/ready stream channels for input and output samples
// ----------------------------------------------------------------------------
interface ctdi_in_if;
	import ctdi_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface ctdi_out_if;
	import ctdi_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    last_of_frame;

	modport source (output valid, output sample_out, output last_of_frame, input ready);
	modport sink   (input valid, input sample_out, input last_of_frame, output ready);
endinterface

// ===== hdl/ctdi_store.sv =====
// ----------------------------------------------------------------------------
// ctdi_store
// sample store: one write and one registered read per cycle, zero sweep after reset
// ----------------------------------------------------------------------------
module ctdi_store (
	input  logic                clk,
	input  logic                arst_n,
	input  ctdi_pkg::ctdi_req_t req,
	output ctdi_pkg::sample_t   rdata,
	output logic                clr_busy
);
	import ctdi_pkg::*;

	sample_t mem [0:(2**ADDR_W)-1];
	sample_t rdata_q;
	addr_t   clr_addr_q;
	logic    clr_busy_q;

	logic    wen;
	addr_t   waddr;
	sample_t wdata;

	// clear sweep owns the write port until it has covered every entry
	always_comb begin
		if (clr_busy_q) begin
			wen   = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			wen   = req.we;
			waddr = req.waddr;
			wdata = req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + addr_t'(1);
			if (clr_addr_q == {ADDR_W{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata    = rdata_q;
	assign clr_busy = clr_busy_q;

endmodule

// ===== hdl/convolutional_time_deinterleaver_core.sv =====
// ----------------------------------------------------------------------------
// convolutional_time_deinterleaver_core
// convolutional time deinterleaver: per-branch frame delay through a sample store
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  rx       | in  | valid / ready | sample_in (16b signed)
//  tx       | out | valid / ready | sample_out (16b signed), last_of_frame
//  cfg      | in  | cfg_we        | cfg_wdata = channel_units (10b)
//
//  one beat per cycle sustained while tx is ready and the zero sweep is done;
//  a beat taken on rx goes through the store read, then the output register
//  the rate is set by the store: one write and one read port, both used per beat
//  after reset a zero sweep covers all 1048576 store entries, one per cycle;
//  rx.ready stays low for that time, cfg writes are taken throughout
//  a stalled tx holds its beat; one more beat is taken into the read stage
//
module convolutional_time_deinterleaver_core (
	input  logic                   clk,
	input  logic                   arst_n,
	ctdi_in_if.sink                rx,
	ctdi_out_if.source             tx,
	input  logic                   cfg_we,
	input  ctdi_pkg::units_t       cfg_wdata
);
	import ctdi_pkg::*;

	// frame counters
	units_t    units_m1_q;     // channel_units - 1
	pos_t      pos_q;          // position of the next sample in its frame
	slot_t     slot_q;         // ring slot of the current frame

	// store access
	ctdi_req_t req;
	sample_t   rdata;
	logic      clr_busy;

	// read stage
	logic      valid_s1;
	logic      fwd_s1;         // zero-delay branch: pass the sample itself
	sample_t   smp_s1;
	logic      last_s1;

	// output register
	logic      out_valid_q;
	sample_t   out_sample_q;
	logic      out_last_q;

	logic      acc;
	logic      adv;
	logic      last;
	slot_t     delay;
	slot_t     rd_slot;
	units_t    units_m1_new;

	// write the new sample into its own slot and read the same position
	// from the slot that lies delay frames back; with delay zero both hit
	// the same entry, so the sample is forwarded instead of read
	assign delay   = DELAY_TAB[pos_q[BRANCH_W-1:0]];
	assign rd_slot = slot_q - delay;
	assign last    = (pos_q == {units_m1_q, {UNIT_LEN_W{1'b1}}});

	assign adv      = valid_s1 && (!out_valid_q || tx.ready);
	assign rx.ready = !clr_busy && (!valid_s1 || adv);
	assign acc      = rx.valid && rx.ready;

	always_comb begin
		req.we    = acc;
		req.waddr = {slot_q, pos_q};
		req.wdata = rx.sample_in;
		req.re    = acc;
		req.raddr = {rd_slot, pos_q};
	end

	ctdi_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rdata    (rdata),
		.clr_busy (clr_busy)
	);

	// unit count of zero counts as one, anything above the maximum as the maximum
	always_comb begin
		if (cfg_wdata == '0) begin
			units_m1_new = '0;
		end else if (cfg_wdata > MAX_UNITS) begin
			units_m1_new = MAX_UNITS - units_t'(1);
		end else begin
			units_m1_new = cfg_wdata - units_t'(1);
		end
	end

	// counters; any config write restarts the frame and the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_m1_q <= '0;
			pos_q      <= '0;
			slot_q     <= '0;
		end else if (cfg_we) begin
			units_m1_q <= units_m1_new;
			pos_q      <= '0;
			slot_q     <= '0;
		end else if (acc) begin
			if (last) begin
				pos_q  <= '0;
				slot_q <= slot_q + slot_t'(1);
			end else begin
				pos_q  <= pos_q + pos_t'(1);
			end
		end
	end

	// read stage: store data arrives here in the cycle after the access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fwd_s1  <= (delay == '0);
			smp_s1  <= rx.sample_in;
			last_s1 <= last;
		end
	end

	// output register parts the tx side from the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_sample_q <= fwd_s1 ? smp_s1 : rdata;
			out_last_q   <= last_s1;
		end
	end

	assign tx.valid         = out_valid_q;
	assign tx.sample_out    = out_sample_q;
	assign tx.last_of_frame = out_last_q;

endmodule
